FILE: hw/rtl/sadc_pkg.sv
// Shared types and constants for the set-associative LRU data cache directory.
`default_nettype none
package sadc_pkg;

  localparam int unsigned SADC_SETS = 64;
  localparam int unsigned SADC_WAYS = 4;
  localparam int unsigned CNT_W     = 15;

  typedef enum logic [2:0] {
    FUNC_LOOKUP   = 3'd0,
    FUNC_FILL     = 3'd1,
    FUNC_INV_LINE = 3'd2,
    FUNC_INV_PAGE = 3'd3,
    FUNC_QUERY    = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_e;

  typedef enum logic {
    CFG_WRITE_NO_ALLOC = 1'b0,
    CFG_SECOND_LEVEL   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [9:0]  set_index;
    logic [31:0] tag_value;
    logic [30:0] use_time;
    logic        write_access;
    logic        keep_lru;
    logic        fill_dirty;
    logic [19:0] page_number;
    logic        match_page;
    logic [31:0] phys_address;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic             victim_dirty;
    logic [31:0]      victim_address;
    logic [CNT_W-1:0] second_level_count;
    logic [CNT_W-1:0] memory_count;
  } rsp_t;

  // one way of a set as held in the directory memory
  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [30:0] ltime;
    logic [31:0] tag;
    logic [19:0] page;
    logic [31:0] addr;
  } line_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sadc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sadc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/set_assoc_lru_data_cache.sv
// Top level of the set-associative data cache tag directory with LRU fill.
//
//  channel   direction  handshake                 word
//  command   in         start / busy              cmd_i (cmd_t)
//  result    out        done_o strobe, no stall   rsp_o (rsp_t)
//  config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Lookup, fill, line invalidate and dirty query read the set from the directory
// RAM on the accept edge, then modify it and write it back in the exec state;
// done_o follows in the next cycle, when busy is low again.
// Page invalidate sweeps every set, one row a cycle.
// Out of range sets (other than for page invalidate) and unused func codes answer zero without leaving idle.
// After reset a clearing pass zeroes every RAM row with busy high.
// The receiver cannot stall; config writes are always taken.
`default_nettype none
module set_assoc_lru_data_cache
  import sadc_pkg::*;
#(
  parameter int unsigned SETS = SADC_SETS,
  parameter int unsigned WAYS = SADC_WAYS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd_i,
  output logic      done_o,
  output rsp_t      rsp_o,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic cfg_index_i,
  input  wire logic cfg_data_i
);

  localparam int unsigned AW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CW    = $clog2(WAYS + 1);
  localparam int unsigned ROW_W = WAYS * $bits(line_t);

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  rsp_t   rsp_q, rsp_d;
  logic   done_q, done_d;
  logic   wna_q, l2en_q;
  logic [AW-1:0]    row_q, row_d;     // clear / sweep row
  logic [CNT_W-1:0] l2_q, l2_d, mem_q, mem_d;
  logic             pfound_q, pfound_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;
  line_t [WAYS-1:0]  rd_lines, new_lines;

  sadc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_dir (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_lines    = ram_rdata;
  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  // set-wide modify of the row just read
  logic          hit, full, q_found, row_hit;
  logic          vd;
  logic [31:0]   va;
  logic [30:0]   best;
  logic [WW-1:0] victim, vmin;
  logic [CW-1:0] row_dirty;

  always_comb begin
    new_lines = rd_lines;
    hit       = 1'b0;
    full      = 1'b1;
    q_found   = 1'b0;
    row_hit   = 1'b0;
    vd        = 1'b0;
    va        = '0;
    best      = rd_lines[0].ltime;
    victim    = '0;
    vmin      = '0;
    row_dirty = '0;
    case (func_e'(cmd_q.func))
      FUNC_LOOKUP: begin
        for (int w = 0; w < WAYS; w++) begin
          if (!hit && rd_lines[w].valid && rd_lines[w].tag == cmd_q.tag_value) begin
            hit = 1'b1;
            if (!cmd_q.keep_lru) new_lines[w].ltime = cmd_q.use_time;
            if (cmd_q.write_access && !wna_q) new_lines[w].dirty = 1'b1;
          end
        end
      end
      FUNC_FILL: begin
        for (int w = 0; w < WAYS; w++) begin
          if (full && !rd_lines[w].valid) begin
            full   = 1'b0;
            victim = WW'(w);
          end
        end
        for (int w = 1; w < WAYS; w++) begin
          if (rd_lines[w].ltime < best) begin
            best = rd_lines[w].ltime;
            vmin = WW'(w);
          end
        end
        if (full) begin
          victim = vmin;
          vd     = rd_lines[vmin].dirty;
          va     = rd_lines[vmin].addr;
        end
        new_lines[victim] = '{valid: 1'b1, dirty: cmd_q.fill_dirty,
                              ltime: cmd_q.use_time, tag: cmd_q.tag_value,
                              page: cmd_q.page_number, addr: cmd_q.phys_address};
      end
      FUNC_INV_LINE: begin
        for (int w = 0; w < WAYS; w++) begin
          if (rd_lines[w].valid && rd_lines[w].tag == cmd_q.tag_value) begin
            if (rd_lines[w].dirty) row_dirty = row_dirty + CW'(1);
            new_lines[w] = '0;
          end
        end
      end
      FUNC_INV_PAGE: begin
        for (int w = 0; w < WAYS; w++) begin
          if (rd_lines[w].valid && rd_lines[w].page == cmd_q.page_number) begin
            if (rd_lines[w].dirty) row_dirty = row_dirty + CW'(1);
            new_lines[w] = '0;
            row_hit      = 1'b1;
          end
        end
      end
      FUNC_QUERY: begin
        for (int w = 0; w < WAYS; w++) begin
          if (!hit && rd_lines[w].valid && rd_lines[w].tag == cmd_q.tag_value &&
              (!cmd_q.match_page || rd_lines[w].page == cmd_q.page_number)) begin
            hit     = 1'b1;
            q_found = rd_lines[w].dirty;
          end
        end
      end
      default: ;
    endcase
  end

  // control: accept, RAM port steering and result assembly
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    row_d     = row_q;
    l2_d      = l2_q;
    mem_d     = mem_q;
    pfound_d  = pfound_q;
    ram_we    = 1'b0;
    ram_waddr = cmd_q.set_index[AW-1:0];
    ram_wdata = new_lines;
    ram_re    = 1'b0;
    ram_raddr = cmd_i.set_index[AW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = row_q;
        ram_wdata = '0;
        row_d     = row_q + AW'(1);
        if (row_q == AW'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          if (func_e'(cmd_i.func) == FUNC_INV_PAGE) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            row_d     = '0;
            l2_d      = '0;
            mem_d     = '0;
            pfound_d  = 1'b0;
            state_d   = ST_SWEEP;
          end else if (32'(cmd_i.set_index) < SETS &&
                       (func_e'(cmd_i.func) == FUNC_LOOKUP ||
                        func_e'(cmd_i.func) == FUNC_FILL ||
                        func_e'(cmd_i.func) == FUNC_INV_LINE ||
                        func_e'(cmd_i.func) == FUNC_QUERY)) begin
            ram_re  = 1'b1;
            state_d = ST_EXEC;
          end else begin
            rsp_d  = '0;
            done_d = 1'b1;
          end
        end
      end
      ST_EXEC: begin
        ram_we  = 1'b1;
        rsp_d   = '0;
        done_d  = 1'b1;
        state_d = ST_IDLE;
        case (func_e'(cmd_q.func))
          FUNC_LOOKUP: rsp_d.found = hit;
          FUNC_FILL: begin
            rsp_d.victim_dirty   = vd;
            rsp_d.victim_address = va;
          end
          FUNC_INV_LINE: begin
            rsp_d.second_level_count = CNT_W'(row_dirty);
            rsp_d.memory_count       = CNT_W'(row_dirty);
          end
          FUNC_QUERY: rsp_d.found = q_found;
          default: ;
        endcase
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = row_q;
        ram_re    = 1'b1;
        ram_raddr = row_q + AW'(1);
        row_d     = row_q + AW'(1);
        pfound_d  = pfound_q | row_hit;
        if (l2en_q) begin
          l2_d = l2_q + CNT_W'(row_dirty);
        end else if (!wna_q) begin
          mem_d = mem_q + CNT_W'(row_dirty);
        end
        if (row_q == AW'(SETS - 1)) begin
          rsp_d                    = '0;
          rsp_d.found              = pfound_d;
          rsp_d.second_level_count = l2_d;
          rsp_d.memory_count       = mem_d;
          done_d                   = 1'b1;
          state_d                  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
      row_q   <= '0;
      wna_q   <= 1'b0;
      l2en_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      row_q   <= row_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_WRITE_NO_ALLOC: wna_q  <= cfg_data_i;
          CFG_SECOND_LEVEL:   l2en_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rsp_q    <= rsp_d;
    l2_q     <= l2_d;
    mem_q    <= mem_d;
    pfound_q <= pfound_d;
  end

  // an accepted command always makes the block busy or answers at once
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && state_q == ST_IDLE) |=> (busy || done_o))
    else $error("accepted command neither busy nor answered");

  // a result strobe is followed by another only when a command was accepted while it was high
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o || $past(start && !busy))
    else $error("result strobe repeated without a command");

  // the directory is written only outside idle
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("directory written while idle");

  // a set modify always ends with a result
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> done_o)
    else $error("set modify ended without a result");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the set-associative LRU data cache tag directory.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import sadc_pkg::*;

  localparam int unsigned NSETS = SADC_SETS;
  localparam int unsigned NWAYS = SADC_WAYS;
  localparam int unsigned NLINES = NSETS * NWAYS;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned N_RANDOM = 400;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_index_i;
  logic cfg_data_i;

  set_assoc_lru_data_cache DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // shadow directory, one entry per set*way
  line_t dir_shadow [NLINES];
  logic  no_alloc_sh;
  logic  l2_en_sh;

  rsp_t  rsp_pending [$];
  int    n_fail;
  int    n_words_in;
  int    n_words_out;
  int    n_hits;
  int    n_victims;
  int    idle_cycles;
  int    send_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Works out the answer to one command and updates the shadow directory.
  function automatic rsp_t cache_predict(cmd_t c);
    rsp_t  r;
    int    base;
    int    vw;
    logic  full;
    logic [30:0] best;
    line_t blank;
    r = '0;
    blank = '0;
    base = int'(c.set_index) * NWAYS;
    if (c.func != FUNC_INV_PAGE && c.set_index >= NSETS) return r;
    case (c.func)
      FUNC_LOOKUP: begin
        for (int w = 0; w < NWAYS; w++) begin
          if (dir_shadow[base+w].valid && dir_shadow[base+w].tag == c.tag_value) begin
            if (!c.keep_lru) dir_shadow[base+w].ltime = c.use_time;
            if (c.write_access && !no_alloc_sh) dir_shadow[base+w].dirty = 1'b1;
            r.found = 1'b1;
            break;
          end
        end
      end
      FUNC_FILL: begin
        vw = 0;
        full = 1'b1;
        for (int w = 0; w < NWAYS; w++) begin
          if (!dir_shadow[base+w].valid) begin
            vw = w;
            full = 1'b0;
            break;
          end
        end
        if (full) begin
          // oldest use time, lowest way on a tie
          best = dir_shadow[base].ltime;
          for (int w = 1; w < NWAYS; w++) begin
            if (dir_shadow[base+w].ltime < best) begin
              best = dir_shadow[base+w].ltime;
              vw = w;
            end
          end
          r.victim_dirty = dir_shadow[base+vw].dirty;
          r.victim_address = dir_shadow[base+vw].addr;
        end
        dir_shadow[base+vw] = '{valid: 1'b1, dirty: c.fill_dirty, ltime: c.use_time,
                                tag: c.tag_value, page: c.page_number,
                                addr: c.phys_address};
      end
      FUNC_INV_LINE: begin
        for (int w = 0; w < NWAYS; w++) begin
          if (dir_shadow[base+w].valid && dir_shadow[base+w].tag == c.tag_value) begin
            if (dir_shadow[base+w].dirty) begin
              r.second_level_count++;
              r.memory_count++;
            end
            dir_shadow[base+w] = blank;
          end
        end
      end
      FUNC_INV_PAGE: begin
        for (int k = 0; k < NLINES; k++) begin
          if (dir_shadow[k].valid && dir_shadow[k].page == c.page_number) begin
            if (dir_shadow[k].dirty) begin
              if (l2_en_sh) r.second_level_count++;
              else if (!no_alloc_sh) r.memory_count++;
            end
            dir_shadow[k] = blank;
            r.found = 1'b1;
          end
        end
      end
      FUNC_QUERY: begin
        for (int w = 0; w < NWAYS; w++) begin
          if (dir_shadow[base+w].valid && dir_shadow[base+w].tag == c.tag_value &&
              (!c.match_page || dir_shadow[base+w].page == c.page_number)) begin
            r.found = dir_shadow[base+w].dirty;
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result checker: every strobe is compared with the oldest expected word.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_words_out++;
      if (rsp_pending.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, rsp_o);
        n_fail++;
      end else begin
        rsp_t e;
        e = rsp_pending.pop_front();
        if (rsp_o.found !== e.found || rsp_o.victim_dirty !== e.victim_dirty ||
            rsp_o.victim_address !== e.victim_address ||
            rsp_o.second_level_count !== e.second_level_count ||
            rsp_o.memory_count !== e.memory_count) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, e, rsp_o);
          n_fail++;
        end
      end
    end
  end

  // Watchdog on cycles with nothing accepted or answered.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("set_assoc_lru_data_cache: mismatch");
      $finish;
    end
  end

  // Issues one command, holding start until it is taken; start stays high
  // afterwards so that a following command can go straight out.
  task automatic send_cmd(cmd_t c, logic has_exp, rsp_t exp_rsp);
    rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    p = cache_predict(c);
    if (has_exp && p !== exp_rsp) begin
      $display("%0t: shadow disagrees with table, expected %p, actual %p", $time,
               exp_rsp, p);
      n_fail++;
    end
    if (c.func == FUNC_LOOKUP && p.found) n_hits++;
    if (p.victim_dirty) n_victims++;
    rsp_pending.push_back(p);
    n_words_in++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (rsp_pending.size() != 0 && guard < IDLE_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (NSETS + 8) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_WRITE_NO_ALLOC) no_alloc_sh = val;
    else l2_en_sh = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic cmd_t mk_cmd(func_e f, int unsigned s, logic [31:0] tag,
                                  logic [30:0] t, logic [19:0] pg, logic [31:0] pa,
                                  logic wr, logic kp, logic fd, logic mp);
    cmd_t c;
    c.func = f;
    c.set_index = s[9:0];
    c.tag_value = tag;
    c.use_time = t;
    c.write_access = wr;
    c.keep_lru = kp;
    c.fill_dirty = fd;
    c.page_number = pg;
    c.match_page = mp;
    c.phys_address = pa;
    return c;
  endfunction

  // Random command mostly aimed at a few hot sets, tags and pages so that
  // hits, full-set fills and invalidations actually happen.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int unsigned r;
    c = cmd_t'({$urandom, $urandom, $urandom, $urandom, 4'($urandom)});
    r = $urandom_range(99);
    if (r < 30) c.func = FUNC_FILL;
    else if (r < 55) c.func = FUNC_LOOKUP;
    else if (r < 68) c.func = FUNC_QUERY;
    else if (r < 80) c.func = FUNC_INV_LINE;
    else if (r < 86) c.func = FUNC_INV_PAGE;
    else if (r < 90) c.func = 3'($urandom_range(5, 7));
    // else fully random func incl. unused codes
    if ($urandom_range(9) < 8) c.set_index = 10'($urandom_range(3));
    else if ($urandom_range(1)) c.set_index = 10'($urandom_range(NSETS - 1));
    if ($urandom_range(9) < 8) c.tag_value = 32'($urandom_range(5));
    if ($urandom_range(9) < 8) c.page_number = 20'($urandom_range(3));
    if ($urandom_range(3) != 0) c.use_time = 31'($urandom_range(15));
    return c;
  endfunction

  typedef struct {
    cmd_t c;
    logic has_exp;
    rsp_t e;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // Expected word from its five fields.
  function automatic rsp_t mk_rsp(logic f, logic vd, logic [31:0] va,
                                  int unsigned l2, int unsigned mem);
    rsp_t r;
    r.found = f;
    r.victim_dirty = vd;
    r.victim_address = va;
    r.second_level_count = CNT_W'(l2);
    r.memory_count = CNT_W'(mem);
    return r;
  endfunction

  initial begin
    rsp_t zero_rsp;
    zero_rsp = '0;
    n_fail = 0;
    n_words_in = 0;
    n_words_out = 0;
    n_hits = 0;
    n_victims = 0;
    idle_cycles = 0;
    send_idle_pct = 34;
    start = 1'b0;
    cmd_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = 1'b0;
    rst_ni = 1'b0;
    foreach (dir_shadow[k]) dir_shadow[k] = '0;
    no_alloc_sh = 1'b0;
    l2_en_sh = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: empty directory, all extremes, every func, full set
    // eviction, LRU ties, out of range set and unused func codes.
    dir_rows.push_back('{mk_cmd(FUNC_LOOKUP, 0, '0, '0, '0, '0, 1, 0, 0, 0), 1, zero_rsp});
    dir_rows.push_back('{mk_cmd(FUNC_QUERY, NSETS-1, '1, '1, '1, '1, 1, 1, 1, 1), 1, zero_rsp});
    dir_rows.push_back('{mk_cmd(FUNC_INV_PAGE, 0, '0, '0, '0, '0, 0, 0, 0, 0), 1, zero_rsp});
    // fill set 5 completely, two ways tying on the oldest time
    dir_rows.push_back('{mk_cmd(FUNC_FILL, 5, 32'h11, 31'd7, 20'h1, 32'hA0, 0, 0, 1, 0), 1, zero_rsp});
    dir_rows.push_back('{mk_cmd(FUNC_FILL, 5, 32'h22, 31'd3, 20'h1, 32'hB0, 0, 0, 0, 0), 1, zero_rsp});
    dir_rows.push_back('{mk_cmd(FUNC_FILL, 5, '1, 31'd3, '1, '1, 0, 0, 1, 0), 1, zero_rsp});
    dir_rows.push_back('{mk_cmd(FUNC_FILL, 5, '0, '1, 20'h2, 32'hD0, 0, 0, 0, 0), 1, zero_rsp});
    // full set: victim is way 1 (time 3, lowest index of the tie), clean
    dir_rows.push_back('{mk_cmd(FUNC_FILL, 5, 32'h33, 31'd9, 20'h2, 32'hE0, 0, 0, 1, 0),
                         1, mk_rsp(0, 0, 32'hB0, 0, 0)});
    // next victim way 2, dirty, all-ones address
    dir_rows.push_back('{mk_cmd(FUNC_FILL, 5, 32'h44, 31'd10, 20'h3, 32'hF0, 0, 0, 0, 0),
                         1, mk_rsp(0, 1, '1, 0, 0)});
    dir_rows.push_back('{mk_cmd(FUNC_LOOKUP, 5, 32'h11, 31'd50, 0, 0, 1, 0, 0, 0),
                         1, mk_rsp(1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(FUNC_LOOKUP, 5, 32'h44, 31'd60, 0, 0, 1, 1, 0, 0), 0, zero_rsp});
    dir_rows.push_back('{mk_cmd(FUNC_QUERY, 5, 32'h44, 0, 20'h3, 0, 0, 0, 0, 1),
                         1, mk_rsp(1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(FUNC_QUERY, 5, 32'h44, 0, 20'h9, 0, 0, 0, 0, 1), 1, zero_rsp});
    dir_rows.push_back('{mk_cmd(FUNC_QUERY, 5, 32'h33, 0, 20'h9, 0, 0, 0, 0, 0),
                         1, mk_rsp(1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(FUNC_INV_LINE, 5, 32'h11, 0, 0, 0, 0, 0, 0, 0),
                         1, mk_rsp(0, 0, 0, 1, 1)});
    dir_rows.push_back('{mk_cmd(FUNC_INV_PAGE, 9, 0, 0, 20'h2, 0, 0, 0, 0, 0),
                         1, mk_rsp(1, 0, 0, 0, 1)});
    // set out of range and unused func codes answer zero and touch nothing
    dir_rows.push_back('{mk_cmd(FUNC_FILL, NSETS, 32'h55, 0, 0, 1, 0, 0, 1, 0), 1, zero_rsp});
    dir_rows.push_back('{mk_cmd(FUNC_LOOKUP, 1023, 32'h44, 0, 0, 0, 1, 0, 0, 0), 1, zero_rsp});
    dir_rows.push_back('{mk_cmd(func_e'(3'd5), 5, 32'h44, 0, 0, 0, 0, 0, 0, 0), 1, zero_rsp});
    dir_rows.push_back('{mk_cmd(func_e'(3'd7), 5, 32'h44, 0, 20'h3, 0, 1, 1, 1, 1), 1, zero_rsp});
    dir_rows.push_back('{mk_cmd(FUNC_INV_LINE, 5, 32'h44, 0, 0, 0, 0, 0, 0, 0),
                         1, mk_rsp(0, 0, 0, 1, 1)});
    foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].has_exp, dir_rows[i].e);
    drain();

    // Random phases over every register setting; sender idle pattern moves
    // from 34% to 50% to none.
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_WRITE_NO_ALLOC, ph[0]);
      write_cfg(CFG_SECOND_LEVEL, ph[1]);
      send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 50 : 0;
      for (int i = 0; i < N_RANDOM / 6; i++) send_cmd(rand_cmd(), 1'b0, zero_rsp);
      drain();
    end

    $display("Ran %0d commands (%0d results), %0d lookup hits, %0d dirty victims,",
             n_words_in, n_words_out, n_hits, n_victims);
    $display("over every write-no-allocate and second-level setting.");
    if (n_fail == 0 && rsp_pending.size() == 0) begin
      $display("set_assoc_lru_data_cache: match");
    end else begin
      $display("set_assoc_lru_data_cache: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/sadc_pkg.sv
hw/rtl/sadc_ram.sv
hw/rtl/set_assoc_lru_data_cache.sv
bench/tb_top.sv
